>>> design/tsbc_pkg.sv
// Shared types and constants for the text screen buffer with cursor.
package tsbc_pkg;

	localparam int CHAR_W    = 8;
	localparam int OUT_COL_W = 6;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	typedef enum logic [2:0] {
		ACT_HOME  = 3'd0,
		ACT_CLEAR = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_READ  = 3'd3,
		ACT_RIGHT = 3'd4,
		ACT_LEFT  = 3'd5,
		ACT_DOWN  = 3'd6,
		ACT_UP    = 3'd7
	} action_t;

	typedef struct packed {
		logic step;
		logic sweep;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} ctrl_sts_t;

endpackage

>>> design/tsbc_datapath.sv
// Datapath: cursor registers, character memory, clearing sweep and result register.
module tsbc_datapath #(
	parameter int COLUMNS = 64,
	parameter int ROWS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsbc_pkg::ctrl_cmd_t                  cmd,
	output tsbc_pkg::ctrl_sts_t                  sts,
	input  tsbc_pkg::action_t                    action,
	input  logic [tsbc_pkg::CHAR_W-1:0]          char_code,
	output logic [tsbc_pkg::CHAR_W-1:0]          read_data,
	output logic [tsbc_pkg::OUT_COL_W-1:0]       cursor_col,
	output logic [tsbc_pkg::OUT_ROW_W-1:0]       cursor_row
);
	import tsbc_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [CW-1:0]     COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0]     ROW_LAST  = RW'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);

	logic [CHAR_W-1:0] mem [CELLS];

	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     row_q, row_d;
	logic [ADDR_W-1:0] cell_q, cell_d;
	logic [ADDR_W-1:0] sweep_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CHAR_W-1:0] wdata;

	logic [CHAR_W-1:0] rd_raw_q;
	logic [CHAR_W-1:0] byp_data_q;
	logic              byp_q;
	logic [CHAR_W-1:0] cur_char;

	logic [CW+OUT_COL_W-1:0] col_ext;
	logic [RW+OUT_ROW_W-1:0] row_ext;

	logic at_first, at_last;

	assign at_first = (col_q == '0) && (row_q == '0);
	assign at_last  = (col_q == COL_LAST) && (row_q == ROW_LAST);

	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		cell_d = cell_q;
		if (cmd.step) begin
			case (action)
				ACT_HOME: begin
					col_d  = '0;
					row_d  = '0;
					cell_d = '0;
				end
				ACT_WRITE, ACT_RIGHT: begin
					if (!at_last) begin
						cell_d = cell_q + 1'b1;
						if (col_q == COL_LAST) begin
							col_d = '0;
							row_d = row_q + 1'b1;
						end else begin
							col_d = col_q + 1'b1;
						end
					end
				end
				ACT_LEFT: begin
					if (!at_first) begin
						cell_d = cell_q - 1'b1;
						if (col_q == '0) begin
							col_d = COL_LAST;
							row_d = row_q - 1'b1;
						end else begin
							col_d = col_q - 1'b1;
						end
					end
				end
				ACT_DOWN: begin
					if (row_q != ROW_LAST) begin
						row_d  = row_q + 1'b1;
						cell_d = cell_q + COL_STEP;
					end
				end
				ACT_UP: begin
					if (row_q != '0) begin
						row_d  = row_q - 1'b1;
						cell_d = cell_q - COL_STEP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign we    = cmd.sweep || (cmd.step && (action == ACT_WRITE));
	assign waddr = cmd.sweep ? sweep_q : cell_q;
	assign wdata = cmd.sweep ? SPACE_CHAR : char_code;

	assign sts.sweep_last = cmd.sweep && (sweep_q == CELL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			cell_q  <= '0;
			sweep_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			cell_q <= cell_d;
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + 1'b1;
			end
			byp_q <= we && (waddr == cell_d);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_raw_q   <= mem[cell_d];
		byp_data_q <= wdata;
	end

	assign cur_char = byp_q ? byp_data_q : rd_raw_q;
	assign col_ext  = {{OUT_COL_W{1'b0}}, col_q};
	assign row_ext  = {{OUT_ROW_W{1'b0}}, row_q};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data  <= cur_char;
			cursor_col <= col_ext[OUT_COL_W-1:0];
			cursor_row <= row_ext[OUT_ROW_W-1:0];
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("cursor row out of range");

	a_cell_track: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cell_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear cell address lost track of the cursor");

	a_no_step_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !cmd.step)
		else $error("command executed during the clearing sweep");

endmodule

>>> design/tsbc_ctrl.sv
// Controller state machine: command acceptance, clearing sweep and result handoff.
module tsbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsbc_pkg::action_t   action,
	output logic                out_valid,
	input  logic                out_ready,
	output tsbc_pkg::ctrl_cmd_t cmd,
	input  tsbc_pkg::ctrl_sts_t sts
);
	import tsbc_pkg::*;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   respond_q;
	logic   out_valid_q;

	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.step     = (state_q == ST_IDLE) && in_valid;
	assign cmd.sweep    = (state_q == ST_SWEEP);
	assign cmd.load_out = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			respond_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sts.sweep_last) begin
						state_q   <= respond_q ? ST_RESULT : ST_IDLE;
						respond_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (action == ACT_CLEAR) begin
							state_q   <= ST_SWEEP;
							respond_q <= 1'b1;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_RESULT: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load_out)
		else $error("pending result overwritten");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> !in_ready)
		else $error("second beat accepted before the result was formed");

endmodule

>>> design/text_screen_buffer_cursor_core.sv
// Top level of the text screen buffer with cursor.
// In a command beat the cursor is updated and any write made at acceptance, and the character
// under the new cursor comes out of the registered memory read port and is loaded into the result
// register once no waiting result blocks the load; the next beat is accepted once that load is
// done. Clearing is a sweep of the single memory write port, one cell per cycle: after reset the
// block clears every cell with s_tready low, and a clear command gives its result after its
// sweep. A waiting result on the master side does not block the next command from being
// accepted, only from being loaded.
module text_screen_buffer_cursor_core #(
	parameter int COLUMNS = 64,
	parameter int ROWS    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tsbc_pkg::CHAR_W-1:0]         s_tdata,  // [7:0] char_code
	input  logic [2:0]                          s_tuser,  // [2:0] action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tsbc_pkg::OUT_TDATA_W-1:0]    m_tdata   // [7:0] read_data, [13:8] cursor_col,
	                                                      // [18:14] cursor_row, [23:19] zero
);
	import tsbc_pkg::*;

	ctrl_cmd_t             cmd;
	ctrl_sts_t             sts;
	action_t               action;
	logic [CHAR_W-1:0]     read_data;
	logic [OUT_COL_W-1:0]  cursor_col;
	logic [OUT_ROW_W-1:0]  cursor_row;

	assign action = action_t'(s_tuser);

	tsbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.action    (action),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tsbc_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.char_code  (s_tdata),
		.read_data  (read_data),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row)
	);

	assign m_tdata = {
		{(OUT_TDATA_W - CHAR_W - OUT_COL_W - OUT_ROW_W){1'b0}},
		cursor_row, cursor_col, read_data
	};

endmodule
